### rtl/ascm_pkg.sv
// Shared types and constants for the allocator size-class mapper.
// No dependencies; imported by the mapper top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package ascm_pkg;

  localparam int unsigned REQ_W     = 32;  // request byte count
  localparam int unsigned BIN_W     = 8;   // bin number
  localparam int unsigned SIZE_W    = 18;  // class size on the result port
  localparam int unsigned FRAC_BITS = 40;  // fraction bits of the growth accumulator

  typedef enum logic {
    REQ_SIZE_TO_BIN = 1'b0,
    REQ_BIN_TO_SIZE = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    GEN_SMALL,
    GEN_GROW,
    GEN_ROUND,
    GEN_FILL,
    GEN_DONE
  } gen_state_e;

endpackage

`default_nettype wire

### rtl/ascm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds one copy of the class-size table.
`timescale 1ns / 1ps
`default_nettype none

module ascm_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 75
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/alloc_size_class_mapper.sv
// Allocator size-class mapper: table generator plus pipelined lookup.
// Depends on ascm_pkg and ascm_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive req_type_i, request_size_i and bin_query_i with start_i
//   high; the word is taken at the rising edge where start_i is high and busy_o low.
//   req_type_i = size-to-bin maps a byte count to its bin; bin-to-size returns the
//   size of bin_query_i (the medium maximum for a bin past the table).
//   Result channel: done_o marks one cycle in which bin_number_o, class_size_o and
//   too_large_o hold the result word; the receiver takes it at the end of that cycle.
//   Reset: a sequencer builds the class-size table one bin at a time (a grow state
//   and a round state per grown medium bin), then repeats the last size to the end
//   of the table; busy_o stays high until the table is complete. After that busy_o
//   stays low for good. Throughput: one word per cycle once busy_o is low.
//   The medium search is a binary search with one step per stage pair (address,
//   then compare on the registered table read); each step has its own table copy.
//   Each accepted word passes the input register, both stages of every search
//   step, the final table read and the output word register. Results come out in
//   order and cannot be held off.
module alloc_size_class_mapper #(
  parameter int unsigned SMALL_BINS   = 16,
  parameter int unsigned TOTAL_BINS   = 75,
  parameter int unsigned SMALL_LIMIT  = 128,
  parameter int unsigned MEDIUM_LIMIT = 131072
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [ascm_pkg::REQ_W-1:0]   request_size_i,
  input  logic [ascm_pkg::BIN_W-1:0]   bin_query_i,
  output logic                         done_o,
  output logic [ascm_pkg::BIN_W-1:0]   bin_number_o,
  output logic [ascm_pkg::SIZE_W-1:0]  class_size_o,
  output logic                         too_large_o
);

  import ascm_pkg::*;

  // Table geometry
  localparam int unsigned TBL_MAX   = (MEDIUM_LIMIT > SMALL_BINS * 8) ?
                                      MEDIUM_LIMIT : SMALL_BINS * 8;
  localparam int unsigned TW        = $clog2(TBL_MAX + 1);
  localparam int unsigned AW        = $clog2(TOTAL_BINS);
  localparam int unsigned IDX_W     = $clog2(TOTAL_BINS + 1);
  localparam int unsigned GROW_MAX  = (MEDIUM_LIMIT * 9 / 8 > SMALL_LIMIT) ?
                                      MEDIUM_LIMIT * 9 / 8 : SMALL_LIMIT;
  localparam int unsigned ACC_INT_W = $clog2(GROW_MAX + 1);
  localparam int unsigned ACC_W     = ACC_INT_W + FRAC_BITS;
  localparam int unsigned RW        = ((ACC_INT_W > TW) ? ACC_INT_W : TW) + 1;
  localparam int unsigned SMALL_END = ((SMALL_BINS < TOTAL_BINS) ?
                                       SMALL_BINS : TOTAL_BINS) - 1;
  localparam bit          GROW_ON   = (SMALL_BINS < TOTAL_BINS) &&
                                      (SMALL_LIMIT < MEDIUM_LIMIT);

  // Search geometry
  localparam int unsigned MED_BINS  = (TOTAL_BINS > SMALL_BINS) ?
                                      TOTAL_BINS - SMALL_BINS : 0;
  localparam int unsigned K         = (MED_BINS > 0) ? $clog2(MED_BINS + 1) : 1;
  localparam int unsigned POS_W     = K;
  localparam int unsigned SUM_W     = $clog2(SMALL_BINS + (1 << K) + 1);
  localparam int unsigned SZ_W      = REQ_W + 1;  // aligned size can reach 2^32
  localparam int unsigned CS_W      = (TW > SIZE_W) ? TW : SIZE_W;

  localparam logic [IDX_W-1:0] SMALL_IDX = IDX_W'(SMALL_BINS);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(TOTAL_BINS - 1);

  typedef struct packed {
    req_type_e          req;
    logic [SZ_W-1:0]    size;
    logic [BIN_W-1:0]   bq;
    logic [POS_W-1:0]   pos;
    logic               rng;
  } item_t;

  // ---------------------------------------------------------------------------
  // Table generator
  // ---------------------------------------------------------------------------
  gen_state_e         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [TW-1:0]      prev_q, prev_d;
  logic [TW-1:0]      last_q;
  logic               gen_we;
  logic [AW-1:0]      gen_waddr;
  logic [TW-1:0]      gen_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_SMALL;
      idx_q   <= '0;
      acc_q   <= {ACC_INT_W'(SMALL_LIMIT), {FRAC_BITS{1'b0}}};
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      prev_q  <= prev_d;
    end
  end

  // Keep the last bin's size for the too-large compare.
  always_ff @(posedge clk_i) begin
    if (gen_we && (gen_waddr == LAST_ADDR)) begin
      last_q <= gen_wdata;
    end
  end

  always_comb begin
    logic [ACC_INT_W-1:0] acc_int;
    logic [RW-1:0]        rnd;
    state_d   = state_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    prev_d    = prev_q;
    gen_we    = 1'b0;
    gen_waddr = idx_q[AW-1:0];
    gen_wdata = prev_q;
    acc_int   = acc_q[ACC_W-1:FRAC_BITS];
    rnd       = '0;
    case (state_q)
      GEN_SMALL: begin
        gen_we    = 1'b1;
        gen_wdata = TW'({idx_q + IDX_W'(1), 3'b000});
        prev_d    = gen_wdata;
        idx_d     = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(SMALL_END)) begin
          state_d = GROW_ON ? GEN_GROW : GEN_FILL;
        end
      end
      GEN_GROW: begin
        // Grow by 9/8, truncating at the fraction width.
        acc_d   = acc_q + (acc_q >> 3);
        state_d = GEN_ROUND;
      end
      GEN_ROUND: begin
        rnd = (RW'(acc_int) + RW'(15)) & ~RW'(15);
        if (rnd <= RW'(SMALL_LIMIT)) begin
          rnd = RW'(SMALL_LIMIT + 16);
        end
        if ((idx_q != SMALL_IDX) && (rnd <= RW'(prev_q))) begin
          rnd = RW'(prev_q) + RW'(16);
        end
        if (rnd > RW'(MEDIUM_LIMIT)) begin
          rnd = RW'(MEDIUM_LIMIT);
        end
        gen_we    = 1'b1;
        gen_wdata = TW'(rnd);
        prev_d    = gen_wdata;
        idx_d     = idx_q + IDX_W'(1);
        if ((rnd < RW'(MEDIUM_LIMIT)) && ((idx_q + IDX_W'(1)) < IDX_W'(TOTAL_BINS)) &&
            (acc_int < ACC_INT_W'(MEDIUM_LIMIT))) begin
          state_d = GEN_GROW;
        end else begin
          state_d = GEN_FILL;
        end
      end
      GEN_FILL: begin
        // Repeat the last size up to the end of the table.
        if (idx_q < IDX_W'(TOTAL_BINS)) begin
          gen_we = 1'b1;
          idx_d  = idx_q + IDX_W'(1);
        end
        if (idx_q >= IDX_W'(TOTAL_BINS - 1)) begin
          state_d = GEN_DONE;
        end
      end
      GEN_DONE: begin
        state_d = GEN_DONE;
      end
      default: begin
        state_d = GEN_DONE;
      end
    endcase
  end

  assign busy_o = (state_q != GEN_DONE);

  // ---------------------------------------------------------------------------
  // Input stage: zero becomes one, then align up to 8
  // ---------------------------------------------------------------------------
  logic  accept;
  item_t in_item;
  item_t b_q     [K+1];
  logic  b_vld_q [K+1];
  item_t a_q     [K];
  logic  a_vld_q [K];

  assign accept = start_i && !busy_o;

  always_comb begin
    logic [SZ_W-1:0] sz;
    sz = (request_size_i == '0) ? SZ_W'(1) : SZ_W'(request_size_i);
    in_item.req  = req_type_e'(req_type_i);
    in_item.size = (sz + SZ_W'(7)) & ~SZ_W'(7);
    in_item.bq   = bin_query_i;
    in_item.pos  = '0;
    in_item.rng  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q[0] <= 1'b0;
    end else begin
      b_vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q[0] <= in_item;
  end

  // ---------------------------------------------------------------------------
  // Medium search: one binary-search step per stage pair. pos counts the
  // medium bins whose size is below the request.
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < K; j++) begin : g_step
    localparam int unsigned STEP = 1 << (K - 1 - j);

    logic [SUM_W-1:0] sum;
    logic             rng;
    logic [AW-1:0]    raddr;
    logic [TW-1:0]    rdata;
    logic             hit;
    item_t            cur;
    item_t            nxt;

    always_comb begin
      sum     = SUM_W'(SMALL_BINS) + SUM_W'(b_q[j].pos) + SUM_W'(STEP - 1);
      rng     = (SUM_W'(b_q[j].pos) + SUM_W'(STEP)) <= SUM_W'(MED_BINS);
      raddr   = rng ? sum[AW-1:0] : '0;
      cur     = b_q[j];
      cur.rng = rng;
    end

    ascm_ram #(
      .WIDTH (TW),
      .DEPTH (TOTAL_BINS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (gen_we),
      .waddr_i (gen_waddr),
      .wdata_i (gen_wdata),
      .raddr_i (raddr),
      .rdata_o (rdata)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[j]   <= 1'b0;
        b_vld_q[j+1] <= 1'b0;
      end else begin
        a_vld_q[j]   <= b_vld_q[j];
        b_vld_q[j+1] <= a_vld_q[j];
      end
    end

    always_comb begin
      hit     = a_q[j].rng && (SZ_W'(rdata) < a_q[j].size);
      nxt     = a_q[j];
      nxt.pos = hit ? (a_q[j].pos + POS_W'(STEP)) : a_q[j].pos;
    end

    always_ff @(posedge clk_i) begin
      a_q[j]   <= cur;
      b_q[j+1] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Bin select and final table read
  // ---------------------------------------------------------------------------
  logic [BIN_W-1:0] fin_bin;
  logic             fin_oor;
  logic             fin_big;
  logic [AW-1:0]    fin_raddr;
  logic [TW-1:0]    fin_rdata;

  always_comb begin
    logic             is_small;
    logic [SZ_W-1:0]  sdiv;
    logic [SUM_W-1:0] mbin;
    is_small = b_q[K].size <= SZ_W'(SMALL_LIMIT);
    sdiv     = (b_q[K].size >> 3) - SZ_W'(1);
    if (sdiv >= SZ_W'(TOTAL_BINS - 1)) begin
      sdiv = SZ_W'(TOTAL_BINS - 1);
    end
    if (SUM_W'(b_q[K].pos) < SUM_W'(MED_BINS)) begin
      mbin = SUM_W'(SMALL_BINS) + SUM_W'(b_q[K].pos);
    end else begin
      mbin = SUM_W'(TOTAL_BINS - 1);
    end
    if (b_q[K].req == REQ_BIN_TO_SIZE) begin
      fin_bin = b_q[K].bq;
    end else if (is_small) begin
      fin_bin = BIN_W'(sdiv);
    end else begin
      fin_bin = BIN_W'(mbin);
    end
    fin_oor   = (b_q[K].req == REQ_BIN_TO_SIZE) && (b_q[K].bq >= BIN_W'(TOTAL_BINS));
    fin_big   = (b_q[K].req == REQ_SIZE_TO_BIN) && (b_q[K].size > SZ_W'(last_q));
    fin_raddr = (fin_bin < BIN_W'(TOTAL_BINS)) ? fin_bin[AW-1:0] : '0;
  end

  ascm_ram #(
    .WIDTH (TW),
    .DEPTH (TOTAL_BINS)
  ) u_ram_fin (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .raddr_i (fin_raddr),
    .rdata_o (fin_rdata)
  );

  logic             f_vld_q;
  logic [BIN_W-1:0] f_bin_q;
  logic             f_oor_q;
  logic             f_big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= b_vld_q[K];
    end
  end

  always_ff @(posedge clk_i) begin
    f_bin_q <= fin_bin;
    f_oor_q <= fin_oor;
    f_big_q <= fin_big;
  end

  // ---------------------------------------------------------------------------
  // Output word register
  // ---------------------------------------------------------------------------
  logic              done_q;
  logic [BIN_W-1:0]  bin_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_d;
  logic              big_q;

  always_comb begin
    logic [CS_W-1:0] cs;
    cs     = f_oor_q ? CS_W'(MEDIUM_LIMIT) : CS_W'(fin_rdata);
    size_d = cs[SIZE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= f_bin_q;
    size_q <= size_d;
    big_q  <= f_big_q;
  end

  assign done_o       = done_q;
  assign bin_number_o = bin_q;
  assign class_size_o = size_q;
  assign too_large_o  = big_q;

endmodule

`default_nettype wire

### rtl/ascm_checker.sv
// Port-level checks for the allocator size-class mapper, bound to its top level.
// Depends on ascm_pkg and alloc_size_class_mapper.
`timescale 1ns / 1ps
`default_nettype none

module ascm_checker #(
  parameter int unsigned SMALL_BINS = 16,
  parameter int unsigned TOTAL_BINS = 75
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  import ascm_pkg::*;

  localparam int unsigned MED_BINS = (TOTAL_BINS > SMALL_BINS) ?
                                     TOTAL_BINS - SMALL_BINS : 0;
  localparam int unsigned K        = (MED_BINS > 0) ? $clog2(MED_BINS + 1) : 1;
  localparam int unsigned LAT      = 2 * K + 3;

  // No word leaves while the table is still being built.
  a_no_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result word while table build in progress");

  // Once the table is ready the block stays ready.
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose after table build");

  // Every accepted word gives a result at the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted word produced no result");

  // No result without a word accepted at the fixed latency before.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result word without a matching request");

endmodule

bind alloc_size_class_mapper ascm_checker #(
  .SMALL_BINS (SMALL_BINS),
  .TOTAL_BINS (TOTAL_BINS)
) u_ascm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

`default_nettype wire
